// ----- rtl/tpm_pkg.sv -----
`default_nettype none
package tpm_pkg;

  localparam int unsigned CmdW     = 3;
  localparam int unsigned TimerIdW = 8;
  localparam int unsigned DurW     = 24;
  localparam int unsigned ElapsedW = 25;
  localparam int unsigned IncW     = 8;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned AllocW   = 7;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK   = 3'd0,
    CMD_CREATE = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_START  = 3'd3,
    CMD_STOP   = 3'd4,
    CMD_POLL   = 3'd5
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  // one timer slot as it travels around the ring
  typedef struct packed {
    logic                reserved;
    logic                running;
    logic                finished;
    logic [ElapsedW-1:0] elapsed;
    logic [DurW-1:0]     target;
  } timer_t;

endpackage
`default_nettype wire

// ----- rtl/tpm_cell.sv -----
`default_nettype none
module tpm_cell
  import tpm_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   shift_i,
  input  wire timer_t slot_i,
  output timer_t      slot_o
);

  timer_t slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (shift_i) begin
      slot_q <= slot_i;
    end
  end

  assign slot_o = slot_q;

endmodule
`default_nettype wire

// ----- rtl/tpm_exec.sv -----
`default_nettype none
module tpm_exec
  import tpm_pkg::*;
(
  input  wire logic [CmdW-1:0] cmd_i,
  input  wire logic [DurW-1:0] dur_i,
  input  wire logic [IncW-1:0] inc_i,
  input  wire logic            hit_i,    // slot at the head is the addressed timer
  input  wire logic            found_i,  // create already placed earlier in this pass
  input  wire timer_t          slot_i,
  output timer_t               slot_o,
  output logic                 ok_o
);

  logic [ElapsedW-1:0] sum;

  assign sum = slot_i.elapsed + ElapsedW'(inc_i);

  always_comb begin
    slot_o = slot_i;
    ok_o   = 1'b0;
    case (cmd_i)
      CMD_TICK: begin
        if (slot_i.running && slot_i.reserved) begin
          if (sum >= {1'b0, slot_i.target}) begin
            slot_o.running  = 1'b0;
            slot_o.finished = 1'b1;
            slot_o.elapsed  = '0;
          end else begin
            slot_o.elapsed = sum;
          end
        end
      end
      CMD_CREATE: begin
        if (!found_i && !slot_i.reserved) begin
          slot_o.reserved = 1'b1;
          slot_o.running  = 1'b0;
          slot_o.finished = 1'b0;
          slot_o.elapsed  = '0;
          slot_o.target   = dur_i;
          ok_o            = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (hit_i && slot_i.reserved) begin
          slot_o = '0;
          ok_o   = 1'b1;
        end
      end
      CMD_START: begin
        if (hit_i && slot_i.reserved) begin
          slot_o.elapsed  = '0;
          slot_o.finished = 1'b0;
          slot_o.running  = 1'b1;
          ok_o            = 1'b1;
        end
      end
      CMD_STOP: begin
        if (hit_i && slot_i.reserved) begin
          slot_o.running  = 1'b0;
          slot_o.finished = 1'b0;
          slot_o.elapsed  = '0;
          ok_o            = 1'b1;
        end
      end
      CMD_POLL: begin
        // poll ignores the reserved flag
        if (hit_i && slot_i.finished) begin
          slot_o.finished = 1'b0;
          ok_o            = 1'b1;
        end
      end
      default: begin
        slot_o = slot_i;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/timer_pool_manager_core.sv -----
`default_nettype none
// Pool of NUM_TIMERS one-shot timers kept in a ring of cells. Every command
// (tick, create, delete, start, stop, poll) rotates the ring once: each cycle
// the slot at the head passes through a single update unit and re-enters at
// the tail. After a full turn the result moves to the output register once
// that register is free, and the core then returns to idle for the next
// command. Create picks the lowest free timer since the ring presents timers
// in index order. The result register lets a new command start while the
// previous result waits to be taken. The user must write tick_increment
// through cfg_we_i/cfg_wdata_i only while idle; the block does not check it.
module timer_pool_manager_core
  import tpm_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = 128
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [IncW-1:0]     cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [CmdW-1:0]     command_i,
  input  wire logic [TimerIdW-1:0] timer_id_i,
  input  wire logic [DurW-1:0]     duration_ms_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [StatusW-1:0]       status_o,
  output logic [AllocW-1:0]        allocated_index_o
);

  localparam int unsigned IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_DONE  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [IdxW-1:0]     cnt_q, cnt_d;
  logic [IncW-1:0]     inc_q;
  logic [CmdW-1:0]     cmd_q;
  logic [TimerIdW-1:0] id_q;
  logic [DurW-1:0]     dur_q;
  logic                found_q, found_d;
  logic [StatusW-1:0]  res_status_q, res_status_d;
  logic [AllocW-1:0]   res_alloc_q, res_alloc_d;
  logic                out_valid_q;
  logic [StatusW-1:0]  out_status_q;
  logic [AllocW-1:0]   out_alloc_q;

  logic                accept, shift, last, hit, ok, id_bad, out_free;
  logic [StatusW-1:0]  init_status;
  timer_t              head_upd;
  timer_t              ring [NUM_TIMERS];

  assign accept   = in_valid_i && in_ready_o;
  assign shift    = (state_q == S_SWEEP);
  assign last     = (cnt_q == IdxW'(NUM_TIMERS - 1));
  assign hit      = (TimerIdW'(cnt_q) == id_q);
  assign id_bad   = ({1'b0, timer_id_i} >= (TimerIdW + 1)'(NUM_TIMERS));
  assign out_free = !out_valid_q || out_ready_i;

  // ring: cell i takes from cell i+1, the tail takes the updated head
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_ring
    timer_t nxt;
    if (i == NUM_TIMERS - 1) begin : g_tail
      assign nxt = head_upd;
    end else begin : g_mid
      assign nxt = ring[i+1];
    end
    tpm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .slot_i  (nxt),
      .slot_o  (ring[i])
    );
  end

  tpm_exec u_exec (
    .cmd_i   (cmd_q),
    .dur_i   (dur_q),
    .inc_i   (inc_q),
    .hit_i   (hit),
    .found_i (found_q),
    .slot_i  (ring[0]),
    .slot_o  (head_upd),
    .ok_o    (ok)
  );

  always_comb begin
    init_status = ST_REFUSED;
    unique case (command_i) inside
      CMD_TICK:   init_status = ST_OK;
      CMD_CREATE: init_status = ST_REFUSED;
      CMD_DELETE, CMD_START, CMD_STOP, CMD_POLL: begin
        init_status = id_bad ? ST_INVALID : ST_REFUSED;
      end
      default:    init_status = ST_REFUSED;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    found_d      = found_q;
    res_status_d = res_status_q;
    res_alloc_d  = res_alloc_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d      = S_SWEEP;
          cnt_d        = '0;
          found_d      = 1'b0;
          res_status_d = init_status;
          res_alloc_d  = '0;
        end
      end
      S_SWEEP: begin
        if (ok) begin
          res_status_d = ST_OK;
          if (cmd_q == CMD_CREATE) begin
            found_d     = 1'b1;
            res_alloc_d = AllocW'(cnt_q);
          end
        end
        if (last) begin
          state_d = S_DONE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      inc_q       <= IncW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      found_q <= found_d;
      if (cfg_we_i) begin
        inc_q <= cfg_wdata_i;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_alloc_q  <= res_alloc_d;
    if (accept) begin
      cmd_q <= command_i;
      id_q  <= timer_id_i;
      dur_q <= duration_ms_i;
    end
    if (state_q == S_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_alloc_q  <= res_alloc_q;
    end
  end

  assign in_ready_o        = (state_q == S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign allocated_index_o = out_alloc_q;

  a_cnt_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_SWEEP |-> cnt_q == '0)
    else $error("sweep counter not parked outside a sweep");

  a_found_create : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP && found_q) |-> cmd_q == CMD_CREATE)
    else $error("allocation mark set for a non-create command");

  a_sweep_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP && last) |=> state_q == S_DONE)
    else $error("ring sweep did not end after a full turn");

  a_result_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished result not moved to the output register");

endmodule
`default_nettype wire
